/* design/jtb_pkg.sv */
// ----------------------------------------------------------------------------
// jtb_pkg
// Shared types, constants and functions of the JTAG TAP bus monitor.
// ----------------------------------------------------------------------------
package jtb_pkg;

    localparam int MAX_BITS    = 64;
    localparam int CNT_W       = $clog2(MAX_BITS + 1);
    localparam int IDX_W       = $clog2(MAX_BITS);
    localparam int COUNT_W     = 7;
    localparam int VALUE_W     = 64;
    localparam int UNIT_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        TAP_TLR      = 4'd0,
        TAP_RTI      = 4'd1,
        TAP_SEL_DR   = 4'd2,
        TAP_CAP_DR   = 4'd3,
        TAP_SHIFT_DR = 4'd4,
        TAP_EXIT1_DR = 4'd5,
        TAP_PAUSE_DR = 4'd6,
        TAP_EXIT2_DR = 4'd7,
        TAP_UPD_DR   = 4'd8,
        TAP_SEL_IR   = 4'd9,
        TAP_CAP_IR   = 4'd10,
        TAP_SHIFT_IR = 4'd11,
        TAP_EXIT1_IR = 4'd12,
        TAP_PAUSE_IR = 4'd13,
        TAP_EXIT2_IR = 4'd14,
        TAP_UPD_IR   = 4'd15
    } t_tap;

    typedef enum logic [1:0] {
        CAUSE_UNIT  = 2'd0,
        CAUSE_STATE = 2'd1,
        CAUSE_TRST  = 2'd2
    } t_cause;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_STATE = 3'd0,
        CFG_IR_LSB_FIRST  = 3'd1,
        CFG_DR_LSB_FIRST  = 3'd2,
        CFG_BITS_PER_UNIT = 3'd3,
        CFG_TDI_PRESENT   = 3'd4,
        CFG_TDO_PRESENT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_tap              initial_state;
        logic              ir_lsb_first;
        logic              dr_lsb_first;
        logic [UNIT_W-1:0] bits_per_unit;
        logic              tdi_present;
        logic              tdo_present;
    } t_cfg_regs;

    typedef struct packed {
        t_cfg_regs regs;
        logic      init_wr;
        t_tap      init_value;
    } t_cfg;

    typedef struct packed {
        t_tap               frame_state;
        t_tap               next_state;
        logic [VALUE_W-1:0] tdi_value;
        logic [VALUE_W-1:0] tdo_value;
        logic [COUNT_W-1:0] bit_count;
        logic               overflow;
        t_cause             close_cause;
        logic               last;
    } t_result;

    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_push;

    function automatic t_tap tap_next(input t_tap s, input logic tms);
        t_tap r;
        unique case (s)
            TAP_TLR:      r = tms ? TAP_TLR      : TAP_RTI;
            TAP_RTI:      r = tms ? TAP_SEL_DR   : TAP_RTI;
            TAP_SEL_DR:   r = tms ? TAP_SEL_IR   : TAP_CAP_DR;
            TAP_CAP_DR:   r = tms ? TAP_EXIT1_DR : TAP_SHIFT_DR;
            TAP_SHIFT_DR: r = tms ? TAP_EXIT1_DR : TAP_SHIFT_DR;
            TAP_EXIT1_DR: r = tms ? TAP_UPD_DR   : TAP_PAUSE_DR;
            TAP_PAUSE_DR: r = tms ? TAP_EXIT2_DR : TAP_PAUSE_DR;
            TAP_EXIT2_DR: r = tms ? TAP_UPD_DR   : TAP_SHIFT_DR;
            TAP_UPD_DR:   r = tms ? TAP_SEL_DR   : TAP_RTI;
            TAP_SEL_IR:   r = tms ? TAP_TLR      : TAP_CAP_IR;
            TAP_CAP_IR:   r = tms ? TAP_EXIT1_IR : TAP_SHIFT_IR;
            TAP_SHIFT_IR: r = tms ? TAP_EXIT1_IR : TAP_SHIFT_IR;
            TAP_EXIT1_IR: r = tms ? TAP_UPD_IR   : TAP_PAUSE_IR;
            TAP_PAUSE_IR: r = tms ? TAP_EXIT2_IR : TAP_PAUSE_IR;
            TAP_EXIT2_IR: r = tms ? TAP_UPD_IR   : TAP_SHIFT_IR;
            TAP_UPD_IR:   r = tms ? TAP_SEL_DR   : TAP_RTI;
        endcase
        return r;
    endfunction

    function automatic logic [MAX_BITS-1:0] bit_reverse(input logic [MAX_BITS-1:0] v);
        logic [MAX_BITS-1:0] r;
        for (int i = 0; i < MAX_BITS; i++) begin
            r[i] = v[MAX_BITS-1-i];
        end
        return r;
    endfunction

endpackage

/* design/jtb_intf.sv */
// ----------------------------------------------------------------------------
// jtb_intf
// Valid/ready channels of the monitor: sample beats in, frame beats out, and
// the configuration write channel.
// ----------------------------------------------------------------------------
interface jtb_item_if;
    logic valid;
    logic ready;
    logic mode;
    logic tms;
    logic tdi;
    logic tdo;

    modport source (output valid, mode, tms, tdi, tdo, input ready);
    modport sink   (input valid, mode, tms, tdi, tdo, output ready);
endinterface

interface jtb_result_if;
    logic                        valid;
    logic                        ready;
    jtb_pkg::t_tap               frame_state;
    jtb_pkg::t_tap               next_state;
    logic [jtb_pkg::VALUE_W-1:0] tdi_value;
    logic [jtb_pkg::VALUE_W-1:0] tdo_value;
    logic [jtb_pkg::COUNT_W-1:0] bit_count;
    logic                        overflow;
    jtb_pkg::t_cause             close_cause;
    logic                        last;

    modport source (output valid, frame_state, next_state, tdi_value, tdo_value,
                    bit_count, overflow, close_cause, last, input ready);
    modport sink   (input valid, frame_state, next_state, tdi_value, tdo_value,
                    bit_count, overflow, close_cause, last, output ready);
endinterface

interface jtb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [jtb_pkg::CFG_IDX_W-1:0]  index;
    logic [jtb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/jtb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// jtb_cfg_regs
// Configuration register file with a write-only valid/ready port.
// ----------------------------------------------------------------------------
module jtb_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jtb_cfg_if.sink       i_cfg,
    output jtb_pkg::t_cfg o_cfg
);
    import jtb_pkg::*;

    t_cfg_regs r_regs;
    t_cfg_regs n_regs;
    logic      wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_regs = r_regs;
        if (wr) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_INITIAL_STATE: n_regs.initial_state = t_tap'(i_cfg.data[3:0]);
                CFG_IR_LSB_FIRST:  n_regs.ir_lsb_first  = i_cfg.data[0];
                CFG_DR_LSB_FIRST:  n_regs.dr_lsb_first  = i_cfg.data[0];
                CFG_BITS_PER_UNIT: n_regs.bits_per_unit = i_cfg.data[UNIT_W-1:0];
                CFG_TDI_PRESENT:   n_regs.tdi_present   = i_cfg.data[0];
                CFG_TDO_PRESENT:   n_regs.tdo_present   = i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.initial_state <= TAP_TLR;
            r_regs.ir_lsb_first  <= 1'b0;
            r_regs.dr_lsb_first  <= 1'b0;
            r_regs.bits_per_unit <= '0;
            r_regs.tdi_present   <= 1'b1;
            r_regs.tdo_present   <= 1'b1;
        end else begin
            r_regs <= n_regs;
        end
    end

    assign o_cfg.regs       = r_regs;
    assign o_cfg.init_wr    = wr && (t_cfg_idx'(i_cfg.index) == CFG_INITIAL_STATE);
    assign o_cfg.init_value = t_tap'(i_cfg.data[3:0]);

endmodule

/* design/jtb_core.sv */
// ----------------------------------------------------------------------------
// jtb_core
// Input register, TAP tracking, bit collection and frame formatting.
// ----------------------------------------------------------------------------
module jtb_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    jtb_item_if.sink       i_in,
    input  jtb_pkg::t_cfg  i_cfg,
    input  logic           i_room,
    output jtb_pkg::t_push o_push
);
    import jtb_pkg::*;

    logic                r_in_valid;
    logic                r_mode;
    logic                r_tms;
    logic                r_tdi_bit;
    logic                r_tdo_bit;
    t_tap                r_tap;
    logic [MAX_BITS-1:0] r_tdi;
    logic [MAX_BITS-1:0] r_tdo;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_ov;
    logic                r_started;

    t_tap                n_tap;
    logic [MAX_BITS-1:0] n_tdi;
    logic [MAX_BITS-1:0] n_tdo;
    logic [CNT_W-1:0]    n_cnt;
    logic                n_ov;

    logic                proc;
    logic                is_shift;
    logic                collect;
    logic [MAX_BITS-1:0] col_tdi;
    logic [MAX_BITS-1:0] col_tdo;
    logic [CNT_W-1:0]    col_cnt;
    logic                col_ov;
    logic                unit_close;
    logic                state_close;
    logic                trst;
    t_tap                nxt;
    logic                lsb;
    logic [MAX_BITS-1:0] fmt_tdi;
    logic [MAX_BITS-1:0] fmt_tdo;
    t_result             data_res;
    t_result             res_b;

    assign proc        = r_in_valid && i_room;
    assign i_in.ready  = !r_in_valid || proc;
    assign is_shift    = (r_tap == TAP_SHIFT_DR) || (r_tap == TAP_SHIFT_IR);
    assign collect     = proc && !r_mode && is_shift &&
                         (i_cfg.regs.tdi_present || i_cfg.regs.tdo_present);
    assign trst        = proc && r_mode;
    assign nxt         = tap_next(r_tap, r_tms);
    assign state_close = proc && !r_mode && (nxt != r_tap);

    always_comb begin
        col_tdi = r_tdi;
        col_tdo = r_tdo;
        col_cnt = r_cnt;
        col_ov  = r_ov;
        if (collect) begin
            if (r_cnt == CNT_W'(MAX_BITS)) begin
                col_ov = 1'b1;
            end else begin
                col_tdi[r_cnt[IDX_W-1:0]] = r_tdi_bit;
                col_tdo[r_cnt[IDX_W-1:0]] = r_tdo_bit;
                col_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    assign unit_close = collect && (i_cfg.regs.bits_per_unit != '0) &&
                        (COUNT_W'(col_cnt) >= i_cfg.regs.bits_per_unit);

    assign lsb = (r_tap == TAP_SHIFT_IR) ? i_cfg.regs.ir_lsb_first
                                         : i_cfg.regs.dr_lsb_first;

    always_comb begin
        fmt_tdi = lsb ? col_tdi : (bit_reverse(col_tdi) >> (CNT_W'(MAX_BITS) - col_cnt));
        fmt_tdo = lsb ? col_tdo : (bit_reverse(col_tdo) >> (CNT_W'(MAX_BITS) - col_cnt));
        if (!is_shift || !i_cfg.regs.tdi_present) begin
            fmt_tdi = '0;
        end
        if (!is_shift || !i_cfg.regs.tdo_present) begin
            fmt_tdo = '0;
        end
    end

    always_comb begin
        data_res.frame_state = r_tap;
        data_res.next_state  = r_tap;
        data_res.tdi_value   = VALUE_W'(fmt_tdi);
        data_res.tdo_value   = VALUE_W'(fmt_tdo);
        data_res.bit_count   = is_shift ? COUNT_W'(col_cnt) : '0;
        data_res.overflow    = is_shift && col_ov;
        data_res.close_cause = CAUSE_UNIT;
        data_res.last        = 1'b0;

        res_b             = data_res;
        res_b.next_state  = nxt;
        res_b.close_cause = CAUSE_STATE;
        res_b.last        = 1'b1;
        if (unit_close) begin
            res_b.tdi_value = '0;
            res_b.tdo_value = '0;
            res_b.bit_count = '0;
            res_b.overflow  = 1'b0;
        end

        o_push.valid0 = 1'b0;
        o_push.valid1 = 1'b0;
        o_push.res0   = data_res;
        o_push.res1   = res_b;
        if (trst) begin
            o_push.valid0           = 1'b1;
            o_push.res0.next_state  = TAP_TLR;
            o_push.res0.close_cause = CAUSE_TRST;
            o_push.res0.last        = 1'b1;
        end else if (unit_close) begin
            o_push.valid0      = 1'b1;
            o_push.valid1      = state_close;
            o_push.res0.last   = !state_close;
        end else if (state_close) begin
            o_push.valid0 = 1'b1;
            o_push.res0   = res_b;
        end
    end

    always_comb begin
        n_tap = r_tap;
        n_tdi = r_tdi;
        n_tdo = r_tdo;
        n_cnt = r_cnt;
        n_ov  = r_ov;
        if (proc) begin
            n_tap = trst ? TAP_TLR : nxt;
            if (trst || unit_close || state_close) begin
                n_tdi = '0;
                n_tdo = '0;
                n_cnt = '0;
                n_ov  = 1'b0;
            end else begin
                n_tdi = col_tdi;
                n_tdo = col_tdo;
                n_cnt = col_cnt;
                n_ov  = col_ov;
            end
        end else if (!r_started && i_cfg.init_wr) begin
            n_tap = i_cfg.init_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_tap      <= TAP_TLR;
            r_tdi      <= '0;
            r_tdo      <= '0;
            r_cnt      <= '0;
            r_ov       <= 1'b0;
            r_started  <= 1'b0;
        end else begin
            r_in_valid <= (i_in.valid && i_in.ready) || (r_in_valid && !proc);
            r_tap      <= n_tap;
            r_tdi      <= n_tdi;
            r_tdo      <= n_tdo;
            r_cnt      <= n_cnt;
            r_ov       <= n_ov;
            r_started  <= r_started || proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_mode    <= i_in.mode;
            r_tms     <= i_in.tms;
            r_tdi_bit <= i_in.tdi;
            r_tdo_bit <= i_in.tdo;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_BITS))
        else $error("Shift count exceeds the store width.");

    a_trst_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trst |=> (r_tap == TAP_TLR) && (r_cnt == '0) && !r_ov)
        else $error("TRST did not return the TAP to Test-Logic-Reset.");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (unit_close || state_close) |=> (r_cnt == '0) && (r_tdi == '0) && (r_tdo == '0))
        else $error("Closed frame left bits in the store.");

endmodule

/* design/jtb_result_queue.sv */
// ----------------------------------------------------------------------------
// jtb_result_queue
// Collapsing result queue that takes up to two frames per cycle and hands one
// frame per beat to the output channel.
// ----------------------------------------------------------------------------
module jtb_result_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jtb_pkg::t_push i_push,
    output logic           o_room,
    jtb_result_if.source   o_out
);
    import jtb_pkg::*;

    t_result           r_q [QUEUE_DEPTH];
    t_result           n_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_count;
    logic [QPTR_W-1:0] n_count;
    logic [QPTR_W-1:0] base;
    logic              pop;

    assign o_out.valid = (r_count != '0);
    assign pop         = o_out.valid && o_out.ready;
    assign o_room      = (r_count <= QPTR_W'(QUEUE_DEPTH - 2));
    assign base        = r_count - QPTR_W'(pop);
    assign n_count     = base + QPTR_W'(i_push.valid0) + QPTR_W'(i_push.valid1);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            n_q[i] = pop ? r_q[i+1] : r_q[i];
        end
        n_q[QUEUE_DEPTH-1] = r_q[QUEUE_DEPTH-1];
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_push.valid0 && (QPTR_W'(i) == base)) begin
                n_q[i] = i_push.res0;
            end
            if (i_push.valid1 && (QPTR_W'(i) == base + QPTR_W'(1))) begin
                n_q[i] = i_push.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_out.frame_state = r_q[0].frame_state;
    assign o_out.next_state  = r_q[0].next_state;
    assign o_out.tdi_value   = r_q[0].tdi_value;
    assign o_out.tdo_value   = r_q[0].tdo_value;
    assign o_out.bit_count   = r_q[0].bit_count;
    assign o_out.overflow    = r_q[0].overflow;
    assign o_out.close_cause = r_q[0].close_cause;
    assign o_out.last        = r_q[0].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QPTR_W'(QUEUE_DEPTH))
        else $error("Result queue count exceeds its depth.");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid0 |-> o_room)
        else $error("Frames pushed without room in the result queue.");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid1 |-> i_push.valid0)
        else $error("Second frame pushed without a first one.");

endmodule

/* design/jtag_tap_bus_monitor_top.sv */
// Path: a frame closed by a sample beat passes the input register and then the result queue
// before it is offered; while the queue lacks room the beat waits in the input register.
// Throughput: one sample beat per cycle while the result queue has room; a beat that closes two
// frames takes two output beats, and a four-entry result queue absorbs the difference.
// Reset: synchronous, active low; TAP tracking returns to Test-Logic-Reset, the bit
// store and the queue empty at once, and configuration takes its reset values.
// ----------------------------------------------------------------------------
// jtag_tap_bus_monitor_top
// Passive JTAG monitor that follows the TAP controller and reports shift frames.
// ----------------------------------------------------------------------------
module jtag_tap_bus_monitor_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jtb_item_if.sink     i_in,
    jtb_cfg_if.sink      i_cfg,
    jtb_result_if.source o_out
);
    import jtb_pkg::*;

    t_cfg  cfg;
    t_push push;
    logic  room;

    jtb_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    jtb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_room  (room),
        .o_push  (push)
    );

    jtb_result_queue u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

/* sim/jtag_tap_bus_monitor_top_test.sv */
// ----------------------------------------------------------------------------
// jtag_tap_bus_monitor_top_test
// Drives TCK sample beats and TRST events into the JTAG TAP monitor, follows
// the TAP controller and the open frame in a local predictor, and compares
// every frame beat field by field under changing register settings.
// ----------------------------------------------------------------------------
module jtag_tap_bus_monitor_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import jtb_pkg::*;

    localparam logic MODE_TCK  = 1'b0;
    localparam logic MODE_TRST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int DRAIN_CYCLES = 4;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASES       = 10;
    localparam int PHASE_BEATS  = 130;

    localparam t_tap TMS_LOW_NEXT [16] = '{
        TAP_RTI, TAP_RTI, TAP_CAP_DR, TAP_SHIFT_DR, TAP_SHIFT_DR, TAP_PAUSE_DR,
        TAP_PAUSE_DR, TAP_SHIFT_DR, TAP_RTI, TAP_CAP_IR, TAP_SHIFT_IR, TAP_SHIFT_IR,
        TAP_PAUSE_IR, TAP_PAUSE_IR, TAP_SHIFT_IR, TAP_RTI
    };
    localparam t_tap TMS_HIGH_NEXT [16] = '{
        TAP_TLR, TAP_SEL_DR, TAP_SEL_IR, TAP_EXIT1_DR, TAP_EXIT1_DR, TAP_UPD_DR,
        TAP_EXIT2_DR, TAP_UPD_DR, TAP_SEL_DR, TAP_TLR, TAP_EXIT1_IR, TAP_EXIT1_IR,
        TAP_UPD_IR, TAP_EXIT2_IR, TAP_UPD_IR, TAP_SEL_DR
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    jtb_item_if   in_if ();
    jtb_cfg_if    cfg_if ();
    jtb_result_if out_if ();

    jtag_tap_bus_monitor_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    // Register mirror.
    t_tap         init_reg = TAP_TLR;
    logic         ir_lsb   = 1'b0;
    logic         dr_lsb   = 1'b0;
    logic [6:0]   unit_len = '0;
    logic         tdi_on   = 1'b1;
    logic         tdo_on   = 1'b1;

    // TAP and open frame mirror.
    t_tap         tap_now       = TAP_TLR;
    t_tap         open_state    = TAP_TLR;
    logic [63:0]  tdi_bits      = '0;
    logic [63:0]  tdo_bits      = '0;
    logic [6:0]   bits_held     = '0;
    logic         dropped       = 1'b0;
    logic         sampling_on   = 1'b0;

    t_result      frame_q [$];

    bit           src_calm   = 1'b0;
    bit           sink_calm  = 1'b0;
    int           shift_left = -1;
    int           errors         = 0;
    int           beats_sent     = 0;
    int           trst_sent      = 0;
    int           frames_checked = 0;
    int           overflow_seen  = 0;
    int           settings_run   = 0;
    int           quiet_cycles   = 0;

    function automatic logic [63:0] first_bit_high(input logic [63:0] v, input int n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++) begin
            r[n-1-i] = v[i];
        end
        return r;
    endfunction

    function automatic bit in_shift(input t_tap s);
        return (s == TAP_SHIFT_DR) || (s == TAP_SHIFT_IR);
    endfunction

    function automatic t_result close_frame(input t_tap nxt, input t_cause cause);
        t_result r;
        logic    low_first;
        r = '0;
        r.frame_state = open_state;
        r.next_state  = nxt;
        r.close_cause = cause;
        if (in_shift(open_state)) begin
            low_first   = (open_state == TAP_SHIFT_IR) ? ir_lsb : dr_lsb;
            r.bit_count = bits_held;
            r.tdi_value = low_first ? tdi_bits : first_bit_high(tdi_bits, bits_held);
            r.tdo_value = low_first ? tdo_bits : first_bit_high(tdo_bits, bits_held);
            if (!tdi_on) r.tdi_value = '0;
            if (!tdo_on) r.tdo_value = '0;
            r.overflow = dropped;
        end
        tdi_bits   = '0;
        tdo_bits   = '0;
        bits_held  = '0;
        dropped    = 1'b0;
        open_state = nxt;
        return r;
    endfunction

    function automatic void predict_frames(input logic mode, input logic tms,
                                           input logic tdi, input logic tdo);
        t_result made [2];
        int      n;
        t_tap    nxt;
        n = 0;
        sampling_on = 1'b1;
        if (mode == MODE_TRST) begin
            tap_now = TAP_TLR;
            made[n] = close_frame(TAP_TLR, CAUSE_TRST);
            n++;
        end else begin
            if (in_shift(open_state) && (tdi_on || tdo_on)) begin
                if (bits_held >= MAX_BITS) begin
                    dropped = 1'b1;
                end else begin
                    tdi_bits[bits_held] = tdi;
                    tdo_bits[bits_held] = tdo;
                    bits_held++;
                end
                if (unit_len != 0 && bits_held >= unit_len) begin
                    made[n] = close_frame(tap_now, CAUSE_UNIT);
                    n++;
                end
            end
            nxt = tms ? TMS_HIGH_NEXT[tap_now] : TMS_LOW_NEXT[tap_now];
            if (nxt != tap_now) begin
                tap_now = nxt;
                made[n] = close_frame(nxt, CAUSE_STATE);
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) made[i].last = 1'b1;
            frame_q = {frame_q, made[i]};
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_INITIAL_STATE: begin
                init_reg = t_tap'(data[3:0]);
                if (!sampling_on) begin
                    tap_now    = init_reg;
                    open_state = init_reg;
                end
            end
            CFG_IR_LSB_FIRST:  ir_lsb   = data[0];
            CFG_DR_LSB_FIRST:  dr_lsb   = data[0];
            CFG_BITS_PER_UNIT: unit_len = data[6:0];
            CFG_TDI_PRESENT:   tdi_on   = data[0];
            CFG_TDO_PRESENT:   tdo_on   = data[0];
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic set_config(input t_tap init, input logic ir, input logic dr,
                              input logic [6:0] unit, input logic ti, input logic to);
        write_reg(CFG_INITIAL_STATE, {3'($urandom), init});
        write_reg(CFG_IR_LSB_FIRST,  {6'($urandom), ir});
        write_reg(CFG_DR_LSB_FIRST,  {6'($urandom), dr});
        write_reg(CFG_BITS_PER_UNIT, unit);
        write_reg(CFG_TDI_PRESENT,   {6'($urandom), ti});
        write_reg(CFG_TDO_PRESENT,   {6'($urandom), to});
        settings_run++;
    endtask

    task automatic send_beat(input logic mode, input logic tms,
                             input logic tdi, input logic tdo);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.mode  <= mode;
        in_if.tms   <= tms;
        in_if.tdi   <= tdi;
        in_if.tdo   <= tdo;
        do @(posedge i_clk); while (!in_if.ready);
        predict_frames(mode, tms, tdi, tdo);
        beats_sent++;
        if (mode == MODE_TRST) trst_sent++;
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic steer_tms();
        logic tms;
        case (tap_now)
            TAP_TLR:                  tms = ($urandom_range(0, 7) == 0);
            TAP_RTI:                  tms = ($urandom_range(0, 3) != 0);
            TAP_SEL_IR:               tms = ($urandom_range(0, 9) == 0);
            TAP_CAP_DR, TAP_CAP_IR:   tms = ($urandom_range(0, 7) == 0);
            TAP_PAUSE_DR, TAP_PAUSE_IR: tms = ($urandom_range(0, 2) == 0);
            TAP_SHIFT_DR, TAP_SHIFT_IR: begin
                if (shift_left < 0) begin
                    shift_left = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 72)
                                                               : $urandom_range(1, 12);
                end
                tms = (shift_left <= 1);
                shift_left--;
            end
            default:                  tms = 1'($urandom_range(0, 1));
        endcase
        return tms;
    endfunction

    task automatic walk_beats(input int count);
        int   r;
        logic tms;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                src_calm  = ($urandom_range(0, 3) == 0);
                sink_calm = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 2) begin
                send_beat(MODE_TRST, 1'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                tms = (r < 10) ? 1'($urandom) : steer_tms();
                send_beat(MODE_TCK, tms, 1'($urandom), 1'($urandom));
            end
            if (!in_shift(tap_now)) shift_left = -1;
        end
    endtask

    task automatic test_initial_state();
        write_reg(CFG_INITIAL_STATE, {3'b111, TAP_UPD_IR});
        write_reg(CFG_INITIAL_STATE, {3'b010, TAP_SHIFT_IR});
        send_beat(MODE_TCK, 1'b0, 1'b1, 1'b0);
        send_beat(MODE_TCK, 1'b0, 1'b0, 1'b1);
        send_beat(MODE_TCK, 1'b0, 1'b1, 1'b1);
        send_beat(MODE_TCK, 1'b1, 1'b1, 1'b0);
        send_beat(MODE_TCK, 1'b1, 1'b0, 1'b0);
        send_beat(MODE_TCK, 1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_unit_close();
        settle();
        write_reg(CFG_BITS_PER_UNIT, 7'd2);
        write_reg(CFG_DR_LSB_FIRST, 7'b1010101);
        send_beat(MODE_TCK, 1'b0, 1'b0, 1'b0);
        send_beat(MODE_TCK, 1'b0, 1'b0, 1'b0);
        send_beat(MODE_TCK, 1'b0, 1'b1, 1'b0);
        send_beat(MODE_TCK, 1'b0, 1'b1, 1'b1);
        send_beat(MODE_TCK, 1'b0, 1'b0, 1'b1);
        send_beat(MODE_TCK, 1'b1, 1'b1, 1'b1);
        send_beat(MODE_TCK, 1'b1, 1'b0, 1'b0);
        send_beat(MODE_TCK, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_trst();
        settle();
        write_reg(CFG_BITS_PER_UNIT, 7'd0);
        send_beat(MODE_TCK, 1'b1, 1'b0, 1'b0);
        send_beat(MODE_TCK, 1'b0, 1'b0, 1'b0);
        send_beat(MODE_TCK, 1'b0, 1'b0, 1'b0);
        send_beat(MODE_TCK, 1'b0, 1'b1, 1'b1);
        send_beat(MODE_TCK, 1'b0, 1'b0, 1'b0);
        send_beat(MODE_TRST, 1'b1, 1'b1, 1'b1);
        send_beat(MODE_TRST, 1'b0, 1'b0, 1'b0);
        send_beat(MODE_TCK, 1'b1, 1'b1, 1'b1);
        send_beat(MODE_TCK, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_random_walk();
        logic [6:0] unit;
        logic       ti;
        logic       to;
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: set_config(TAP_TLR, 1'b0, 1'b0, 7'd0, 1'b1, 1'b1);
                1: set_config(TAP_UPD_IR, 1'b1, 1'b0, 7'd1, 1'b1, 1'b1);
                2: set_config(TAP_RTI, 1'b0, 1'b1, 7'd64, 1'b1, 1'b1);
                3: begin
                    set_config(TAP_SHIFT_DR, 1'b1, 1'b1, 7'd127, 1'b1, 1'b1);
                    write_reg(CFG_SPARE_LO, 7'($urandom));
                    write_reg(CFG_SPARE_HI, 7'($urandom));
                end
                4: set_config(TAP_TLR, 1'b0, 1'b1, 7'd65, 1'b0, 1'b1);
                5: set_config(TAP_PAUSE_IR, 1'b1, 1'b0, 7'($urandom_range(2, 16)),
                              1'b1, 1'b0);
                6: set_config(TAP_SHIFT_IR, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0);
                default: begin
                    unit = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                       : 7'($urandom_range(0, 20));
                    ti = ($urandom_range(0, 3) != 0);
                    to = ($urandom_range(0, 3) != 0);
                    set_config(t_tap'($urandom_range(0, 15)), 1'($urandom), 1'($urandom),
                               unit, ti, to);
                end
            endcase
            walk_beats(PHASE_BEATS);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : frame_check
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            frames_checked++;
            if (out_if.overflow === 1'b1) overflow_seen++;
            if (frame_q.size() == 0) begin
                $error("frame beat with no frame expected: state %0d", out_if.frame_state);
                errors++;
            end else begin
                want = frame_q.pop_front();
                check_field("frame_state", want.frame_state, out_if.frame_state);
                check_field("next_state",  want.next_state,  out_if.next_state);
                check_field("tdi_value",   want.tdi_value,   out_if.tdi_value);
                check_field("tdo_value",   want.tdo_value,   out_if.tdo_value);
                check_field("bit_count",   want.bit_count,   out_if.bit_count);
                check_field("overflow",    want.overflow,    out_if.overflow);
                check_field("close_cause", want.close_cause, out_if.close_cause);
                check_field("last",        want.last,        out_if.last);
            end
        end
    end

    initial begin : frame_sink
        int stall;
        out_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        in_if.valid  <= 1'b0;
        in_if.mode   <= MODE_TCK;
        in_if.tms    <= 1'b0;
        in_if.tdi    <= 1'b0;
        in_if.tdo    <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_initial_state();
        test_unit_close();
        test_trst();
        test_random_walk();
        settle();
        repeat (10) @(posedge i_clk);
        if (frame_q.size() != 0) begin
            $error("%0d expected frames never arrived", frame_q.size());
            errors++;
        end
        $display("Drove %0d TCK and TRST beats (%0d TRST) under %0d register settings.",
                 beats_sent, trst_sent, settings_run);
        $display("Compared %0d frame beats, %0d of them with dropped bits.",
                 frames_checked, overflow_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
